### hdl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// shared codes and types of the priority scheduler with aging
// ----------------------------------------------------------------------------
package psa_pkg;

   // event codes
   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_ADD     = 3'd1;
   localparam logic [2:0] MODE_REMOVE  = 3'd2;
   localparam logic [2:0] MODE_BLOCK   = 3'd3;
   localparam logic [2:0] MODE_UNBLOCK = 3'd4;
   localparam logic [2:0] MODE_SETPRIO = 3'd5;
   localparam logic [2:0] MODE_GETPRIO = 3'd6;

   // status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_BAD_SLOT = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_BAD_PRIO = 3'd3;
   localparam logic [2:0] STATUS_IDLE     = 3'd4;

   // task states
   localparam logic [1:0] TASK_READY   = 2'd0;
   localparam logic [1:0] TASK_RUNNING = 2'd1;
   localparam logic [1:0] TASK_BLOCKED = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_AGING_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_AGING_INTERVAL  = 2'd1;
   localparam logic [1:0] CSR_NEW_TASK_PRIO   = 2'd2;

   // per-cell control
   typedef struct packed {
      logic shift;
      logic load;
   } psa_cellop_type;

   // per-queue control
   typedef struct packed {
      logic push;
      logic drop;
   } psa_qop_type;

endpackage

### hdl/psa_cell.sv
// ----------------------------------------------------------------------------
// psa_cell
// one queue entry; takes its right neighbor on a shift, new data on a load
// ----------------------------------------------------------------------------
module psa_cell #(
   parameter int W = 4
) (
   input  logic                     clock,
   input  psa_pkg::psa_cellop_type  op,
   input  logic [W-1:0]             nb_data,
   input  logic [W-1:0]             load_data,
   output logic [W-1:0]             data
);

   logic [W-1:0] data_ff;
   logic [W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (op.shift) begin
         data_in = nb_data;
      end else if (op.load) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### hdl/psa_queue.sv
// ----------------------------------------------------------------------------
// psa_queue
// one priority level fifo built as a chain of cells with a fill count
// ----------------------------------------------------------------------------
module psa_queue #(
   parameter int N  = 16,
   parameter int SW = 4,
   parameter int CW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psa_pkg::psa_qop_type  op,
   input  logic [SW-1:0]         push_data,
   input  logic [SW-1:0]         idx,
   output logic [SW-1:0]         rd_data,
   output logic [CW-1:0]         len
);

   logic [CW-1:0] len_ff;
   logic [CW-1:0] len_in;
   logic [SW-1:0] cell_data [N];

   for (genvar j = 0; j < N; j++) begin : g_cell
      psa_pkg::psa_cellop_type cop;
      logic [SW-1:0]           nb;
      assign cop.shift = op.drop && (SW'(j) >= idx);
      assign cop.load  = op.push && (len_ff == CW'(j));
      if (j == N - 1) begin : g_end
         assign nb = '0;
      end else begin : g_mid
         assign nb = cell_data[j+1];
      end
      psa_cell #(.W(SW)) u_cell (
         .clock     (clock),
         .op        (cop),
         .nb_data   (nb),
         .load_data (push_data),
         .data      (cell_data[j])
      );
   end

   always_comb begin
      len_in = len_ff;
      if (op.push && len_ff < CW'(N)) begin
         len_in = len_ff + CW'(1);
      end else if (op.drop && len_ff != '0) begin
         len_in = len_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   assign rd_data = cell_data[idx];
   assign len     = len_ff;

endmodule

### hdl/priority_scheduler_with_aging_top.sv
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_top
// task scheduler with per-level fifos, aging and an idle task
// ----------------------------------------------------------------------------
// one event word in, one result word out. events are handled one at a time by
// a sequencer that walks the level fifos (each a chain of cells that shifts
// toward the head) entry by entry. remove, block and set priority scan a fifo
// for the slot; a tick computes the bit-serial tick_count % aging_interval
// remainder, runs the aging pass when it is zero, and chooses the next task.
// no item is taken while a result waits on the rsp side.
module priority_scheduler_with_aging_top #(
   parameter int TASK_SLOTS      = 16,
   parameter int PRIORITY_LEVELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request word: mode[2:0], slot[6:3], priority_req[8:7]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // result word: status_code[2:0], slot_out[6:3], priority_out[8:7],
   // reschedule[9], idle_chosen[10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int N  = TASK_SLOTS;
   localparam int L  = PRIORITY_LEVELS;
   localparam int SW = $clog2(N);
   localparam int LW = $clog2(L);
   localparam int CW = $clog2(N + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_TREQ = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_AGRD = 4'd4;
   localparam logic [3:0] S_AGEV = 4'd5;
   localparam logic [3:0] S_PKRD = 4'd6;
   localparam logic [3:0] S_PKEV = 4'd7;
   localparam logic [3:0] S_TRUN = 4'd8;
   localparam logic [3:0] S_ADD  = 4'd9;
   localparam logic [3:0] S_RMRD = 4'd10;
   localparam logic [3:0] S_RBFN = 4'd11;
   localparam logic [3:0] S_SP2  = 4'd12;

   // configuration
   logic [31:0] thr_ff;
   logic [15:0] iv_ff;
   logic [1:0]  ntp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 32'd20;
         iv_ff  <= 16'd10;
         ntp_ff <= 2'd2;
      end else if (csr_we) begin
         unique case (csr_addr)
            psa_pkg::CSR_AGING_THRESHOLD: thr_ff <= csr_wdata;
            psa_pkg::CSR_AGING_INTERVAL:  iv_ff  <= csr_wdata[15:0];
            psa_pkg::CSR_NEW_TASK_PRIO:   ntp_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // slot table
   logic          used_ff [N];
   logic [1:0]    st_ff   [N];
   logic [LW-1:0] base_ff [N];
   logic [LW-1:0] eff_ff  [N];
   logic [31:0]   lrt_ff  [N];

   // sequencer registers
   logic [3:0]    state_ff, state_in, ret_ff, ret_in;
   logic [2:0]    mode_ff, mode_in;
   logic [3:0]    slot_ff, slot_in;
   logic [1:0]    preq_ff, preq_in;
   logic [SW-1:0] a_ff, a_in;
   logic [LW-1:0] lv_ff, lv_in;
   logic [CW-1:0] k_ff, k_in;
   logic [LW-1:0] ob_ff, ob_in, oe_ff, oe_in;
   logic [15:0]   rem_ff, rem_in;
   logic [4:0]    bc_ff, bc_in;
   logic          runv_ff, runv_in;
   logic [SW-1:0] run_ff, run_in;
   logic [31:0]   tick_ff, tick_in;
   logic [CW-1:0] ucnt_ff, ucnt_in;

   // result register
   logic          rv_ff, rv_in;
   logic [2:0]    status_ff, status_in;
   logic [3:0]    sout_ff, sout_in;
   logic [1:0]    prio_ff, prio_in;
   logic          resch_ff, resch_in;
   logic          idle_ff, idle_in;

   // table write controls, all at a_ff
   logic          we_used, used_wd;
   logic          we_st;
   logic [1:0]    st_wd;
   logic          we_base, we_eff, we_lrt;
   logic [LW-1:0] base_wd, eff_wd;

   // queue controls
   logic          push_en, drop_en;
   logic [LW-1:0] push_lv, drop_lv;
   logic [SW-1:0] q_rd   [L];
   logic [CW-1:0] q_len  [L];

   // table read port
   logic          used_rd;
   logic [1:0]    st_rd;
   logic [LW-1:0] base_rd, eff_rd;
   logic [31:0]   lrt_rd;

   assign used_rd = used_ff[a_ff];
   assign st_rd   = st_ff[a_ff];
   assign base_rd = base_ff[a_ff];
   assign eff_rd  = eff_ff[a_ff];
   assign lrt_rd  = lrt_ff[a_ff];

   for (genvar l = 0; l < L; l++) begin : g_level
      psa_pkg::psa_qop_type qop;
      assign qop.push = push_en && (push_lv == LW'(l));
      assign qop.drop = drop_en && (drop_lv == LW'(l));
      psa_queue #(.N(N), .SW(SW), .CW(CW)) u_queue (
         .clock     (clock),
         .reset     (reset),
         .op        (qop),
         .push_data (a_ff),
         .idx       (k_ff[SW-1:0]),
         .rd_data   (q_rd[l]),
         .len       (q_len[l])
      );
   end

   // first free slot
   logic [SW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int j = N - 1; j >= 0; j--) begin
         if (!used_ff[j]) begin
            free_slot = SW'(j);
         end
      end
   end

   // request decode
   logic          slot_ok, valid_slot, ntp_bad, preq_bad;
   logic [LW-1:0] preq_lv, ntp_lv, lv_dn;
   logic [16:0]   rem_sh, rem_sub;
   logic          aged;

   assign slot_ok    = {28'd0, slot_ff} < 32'(N);
   assign valid_slot = slot_ok && used_rd;
   assign ntp_bad    = {30'd0, ntp_ff} >= 32'(L);
   assign preq_bad   = {30'd0, preq_ff} >= 32'(L);
   assign preq_lv    = LW'({30'd0, preq_ff});
   assign ntp_lv     = LW'({30'd0, ntp_ff});
   assign lv_dn      = lv_ff - LW'(1);
   // one remainder bit per cycle, msb first
   assign rem_sh     = {rem_ff, tick_ff[bc_ff]};
   assign rem_sub    = rem_sh - {1'b0, iv_ff};
   assign aged       = (tick_ff - lrt_rd) >= thr_ff;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      mode_in   = mode_ff;
      slot_in   = slot_ff;
      preq_in   = preq_ff;
      a_in      = a_ff;
      lv_in     = lv_ff;
      k_in      = k_ff;
      ob_in     = ob_ff;
      oe_in     = oe_ff;
      rem_in    = rem_ff;
      bc_in     = bc_ff;
      runv_in   = runv_ff;
      run_in    = run_ff;
      tick_in   = tick_ff;
      ucnt_in   = ucnt_ff;
      rv_in     = rv_ff && !rsp_tready;
      status_in = status_ff;
      sout_in   = sout_ff;
      prio_in   = prio_ff;
      resch_in  = resch_ff;
      idle_in   = idle_ff;
      we_used   = 1'b0;
      used_wd   = 1'b0;
      we_st     = 1'b0;
      st_wd     = psa_pkg::TASK_READY;
      we_base   = 1'b0;
      we_eff    = 1'b0;
      we_lrt    = 1'b0;
      base_wd   = base_rd;
      eff_wd    = eff_rd;
      push_en   = 1'b0;
      push_lv   = '0;
      drop_en   = 1'b0;
      drop_lv   = lv_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in   = req_tdata[2:0];
               slot_in   = req_tdata[6:3];
               preq_in   = req_tdata[8:7];
               a_in      = SW'({28'd0, req_tdata[6:3]});
               status_in = psa_pkg::STATUS_OK;
               sout_in   = req_tdata[6:3];
               prio_in   = '0;
               resch_in  = 1'b0;
               idle_in   = 1'b0;
               state_in  = S_DISP;
            end
         end

         S_DISP: begin
            state_in = S_IDLE;
            rv_in    = 1'b1;
            unique case (mode_ff)
               psa_pkg::MODE_TICK: begin
                  rv_in  = 1'b0;
                  rem_in = '0;
                  bc_in  = 5'd31;
                  if (runv_ff) begin
                     a_in     = run_ff;
                     state_in = S_TREQ;
                  end else begin
                     state_in = S_DIV;
                  end
               end
               psa_pkg::MODE_ADD: begin
                  sout_in = '0;
                  if (ntp_bad) begin
                     status_in = psa_pkg::STATUS_BAD_PRIO;
                  end else if (ucnt_ff >= CW'(N)) begin
                     status_in = psa_pkg::STATUS_FULL;
                  end else begin
                     a_in     = free_slot;
                     rv_in    = 1'b0;
                     state_in = S_ADD;
                  end
               end
               psa_pkg::MODE_REMOVE, psa_pkg::MODE_BLOCK: begin
                  if (!valid_slot) begin
                     status_in = psa_pkg::STATUS_BAD_SLOT;
                  end else if (slot_ff == '0) begin
                     status_in = psa_pkg::STATUS_IDLE;
                  end else begin
                     rv_in = 1'b0;
                     if (st_rd == psa_pkg::TASK_READY || st_rd == psa_pkg::TASK_RUNNING) begin
                        lv_in    = eff_rd;
                        k_in     = '0;
                        ret_in   = S_RBFN;
                        state_in = S_RMRD;
                     end else begin
                        state_in = S_RBFN;
                     end
                  end
               end
               psa_pkg::MODE_UNBLOCK: begin
                  if (!valid_slot || st_rd != psa_pkg::TASK_BLOCKED) begin
                     status_in = psa_pkg::STATUS_BAD_SLOT;
                  end else begin
                     we_eff = 1'b1;
                     eff_wd = base_rd;
                     we_lrt = 1'b1;
                     if (q_len[base_rd] < CW'(N)) begin
                        push_en = 1'b1;
                        push_lv = base_rd;
                        we_st   = 1'b1;
                        st_wd   = psa_pkg::TASK_READY;
                     end else begin
                        status_in = psa_pkg::STATUS_FULL;
                     end
                  end
               end
               psa_pkg::MODE_SETPRIO: begin
                  if (!valid_slot) begin
                     status_in = psa_pkg::STATUS_BAD_SLOT;
                  end else if (slot_ff == '0) begin
                     status_in = psa_pkg::STATUS_IDLE;
                  end else if (preq_bad) begin
                     status_in = psa_pkg::STATUS_BAD_PRIO;
                  end else if (base_rd != preq_lv) begin
                     ob_in   = base_rd;
                     oe_in   = eff_rd;
                     we_base = 1'b1;
                     base_wd = preq_lv;
                     we_eff  = 1'b1;
                     eff_wd  = preq_lv;
                     if (st_rd == psa_pkg::TASK_READY) begin
                        rv_in    = 1'b0;
                        lv_in    = eff_rd;
                        k_in     = '0;
                        ret_in   = S_SP2;
                        state_in = S_RMRD;
                     end
                  end
               end
               psa_pkg::MODE_GETPRIO: begin
                  if (!valid_slot) begin
                     status_in = psa_pkg::STATUS_BAD_SLOT;
                  end else begin
                     prio_in = 2'(base_rd);
                  end
               end
               default: begin
                  status_in = psa_pkg::STATUS_BAD_SLOT;
               end
            endcase
         end

         // running task gives up the cpu and goes back to its base level, unless that level is full
         S_TREQ: begin
            tick_in  = tick_ff + 32'd1;
            we_eff   = 1'b1;
            eff_wd   = base_rd;
            state_in = S_DIV;
            if ((st_rd == psa_pkg::TASK_READY || st_rd == psa_pkg::TASK_RUNNING) &&
                a_ff != '0) begin
               if (q_len[base_rd] < CW'(N)) begin
                  push_en = 1'b1;
                  push_lv = base_rd;
                  we_st   = 1'b1;
                  st_wd   = psa_pkg::TASK_READY;
               end else begin
                  // level full: the current task keeps running
                  we_st     = 1'b1;
                  st_wd     = psa_pkg::TASK_RUNNING;
                  status_in = psa_pkg::STATUS_FULL;
                  sout_in   = 4'(a_ff);
                  rv_in     = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (st_rd == psa_pkg::TASK_RUNNING) begin
               we_st = 1'b1;
               st_wd = psa_pkg::TASK_READY;
            end
         end

         // tick_count % aging_interval, restoring, one bit a cycle
         S_DIV: begin
            if (iv_ff == '0) begin
               lv_in    = '0;
               k_in     = '0;
               state_in = S_PKRD;
            end else begin
               rem_in = (rem_sh >= {1'b0, iv_ff}) ? rem_sub[15:0] : rem_sh[15:0];
               bc_in  = bc_ff - 5'd1;
               if (bc_ff == '0) begin
                  k_in = '0;
                  if (rem_in == '0) begin
                     lv_in    = LW'(L - 1);
                     state_in = S_AGRD;
                  end else begin
                     lv_in    = '0;
                     state_in = S_PKRD;
                  end
               end
            end
         end

         S_AGRD: begin
            if (k_ff >= q_len[lv_ff]) begin
               k_in = '0;
               if (lv_ff == LW'(1)) begin
                  lv_in    = '0;
                  state_in = S_PKRD;
               end else begin
                  lv_in = lv_dn;
               end
            end else begin
               a_in     = q_rd[lv_ff];
               state_in = S_AGEV;
            end
         end

         // promote one level when waited long enough and there is room
         S_AGEV: begin
            state_in = S_AGRD;
            if (32'(a_ff) < 32'(N) && used_rd && aged && q_len[lv_dn] < CW'(N)) begin
               drop_en = 1'b1;
               drop_lv = lv_ff;
               push_en = 1'b1;
               push_lv = lv_dn;
               we_eff  = 1'b1;
               eff_wd  = lv_dn;
               we_lrt  = 1'b1;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end

         // pop heads until a ready task turns up, or pick idle when all levels are empty
         S_PKRD: begin
            if (q_len[lv_ff] == '0) begin
               if (lv_ff == LW'(L - 1)) begin
                  a_in     = '0;
                  idle_in  = 1'b1;
                  state_in = S_TRUN;
               end else begin
                  lv_in = lv_ff + LW'(1);
               end
            end else begin
               a_in     = q_rd[lv_ff];
               drop_en  = 1'b1;
               drop_lv  = lv_ff;
               state_in = S_PKEV;
            end
         end

         S_PKEV: begin
            if (used_rd && st_rd == psa_pkg::TASK_READY) begin
               state_in = S_TRUN;
            end else begin
               state_in = S_PKRD;
            end
         end

         S_TRUN: begin
            we_lrt   = 1'b1;
            we_st    = 1'b1;
            st_wd    = psa_pkg::TASK_RUNNING;
            runv_in  = 1'b1;
            run_in   = a_ff;
            sout_in  = 4'(a_ff);
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end

         S_ADD: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
            if (q_len[ntp_lv] < CW'(N)) begin
               push_en = 1'b1;
               push_lv = ntp_lv;
               we_used = 1'b1;
               used_wd = 1'b1;
               we_st   = 1'b1;
               st_wd   = psa_pkg::TASK_READY;
               we_base = 1'b1;
               base_wd = ntp_lv;
               we_eff  = 1'b1;
               eff_wd  = ntp_lv;
               we_lrt  = 1'b1;
               ucnt_in = ucnt_ff + CW'(1);
               sout_in = 4'(a_ff);
            end else begin
               status_in = psa_pkg::STATUS_FULL;
            end
         end

         // drop the first entry of this slot from level lv_ff
         S_RMRD: begin
            if (k_ff >= q_len[lv_ff]) begin
               state_in = ret_ff;
            end else if (q_rd[lv_ff] == a_ff) begin
               drop_en  = 1'b1;
               drop_lv  = lv_ff;
               state_in = ret_ff;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end

         S_RBFN: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
            if (mode_ff == psa_pkg::MODE_REMOVE) begin
               we_used = 1'b1;
               used_wd = 1'b0;
               ucnt_in = ucnt_ff - CW'(1);
            end else begin
               we_st = 1'b1;
               st_wd = psa_pkg::TASK_BLOCKED;
            end
            if (runv_ff && run_ff == a_ff) begin
               resch_in = 1'b1;
               if (mode_ff == psa_pkg::MODE_REMOVE) begin
                  runv_in = 1'b0;
               end
            end
         end

         // requeue at the new level, or put the old levels back
         S_SP2: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
            we_lrt   = 1'b1;
            if (q_len[preq_lv] < CW'(N)) begin
               push_en = 1'b1;
               push_lv = preq_lv;
            end else begin
               we_base   = 1'b1;
               base_wd   = ob_ff;
               we_eff    = 1'b1;
               eff_wd    = oe_ff;
               push_en   = q_len[oe_ff] < CW'(N);
               push_lv   = oe_ff;
               status_in = psa_pkg::STATUS_FULL;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         runv_ff  <= 1'b0;
         run_ff   <= '0;
         tick_ff  <= '0;
         ucnt_ff  <= CW'(1);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         runv_ff  <= runv_in;
         run_ff   <= run_in;
         tick_ff  <= tick_in;
         ucnt_ff  <= ucnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      mode_ff   <= mode_in;
      slot_ff   <= slot_in;
      preq_ff   <= preq_in;
      a_ff      <= a_in;
      lv_ff     <= lv_in;
      k_ff      <= k_in;
      ob_ff     <= ob_in;
      oe_ff     <= oe_in;
      rem_ff    <= rem_in;
      bc_ff     <= bc_in;
      status_ff <= status_in;
      sout_ff   <= sout_in;
      prio_ff   <= prio_in;
      resch_ff  <= resch_in;
      idle_ff   <= idle_in;
   end

   // slot table; slot 0 is the idle task at the lowest level
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < N; j++) begin
            used_ff[j] <= (j == 0);
            st_ff[j]   <= psa_pkg::TASK_READY;
            base_ff[j] <= (j == 0) ? LW'(L - 1) : '0;
            eff_ff[j]  <= (j == 0) ? LW'(L - 1) : '0;
            lrt_ff[j]  <= '0;
         end
      end else begin
         if (we_used) begin
            used_ff[a_ff] <= used_wd;
         end
         if (we_st) begin
            st_ff[a_ff] <= st_wd;
         end
         if (we_base) begin
            base_ff[a_ff] <= base_wd;
         end
         if (we_eff) begin
            eff_ff[a_ff] <= eff_wd;
         end
         if (we_lrt) begin
            lrt_ff[a_ff] <= tick_ff;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {5'd0, idle_ff, resch_ff, prio_ff, sout_ff, status_ff};

endmodule

### hdl/psa_checker.sv
// ----------------------------------------------------------------------------
// psa_checker
// port-level checks of the scheduler
// ----------------------------------------------------------------------------
module psa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // no new word while a result waits
   a_hold_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");

   // one event at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("back to back request");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // choosing idle runs slot 0 with ok status
   a_idle_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |->
         rsp_tdata[6:3] == 4'd0 && rsp_tdata[2:0] == psa_pkg::STATUS_OK)
      else $error("idle choice with wrong slot or status");

   // status in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= psa_pkg::STATUS_IDLE)
      else $error("status code out of range");

endmodule

bind priority_scheduler_with_aging_top psa_checker u_psa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the priority scheduler with aging: a queue-fed
// driver sends event words, a predictor mirrors the slot table and the level
// fifos, and a monitor compares every result word with the oldest prediction
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;
   localparam int NLVL = 4;
   localparam int CYCLE_LIMIT = 2000000;

   // predicted result word
   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [1:0] prio;
      logic       resched;
      logic       idle;
   } sched_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;

   priority_scheduler_with_aging_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // stimulus and expectation stores
   logic [8:0]       event_backlog[$];
   sched_result_type sched_expected[$];
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int               err_count;
   int               cycle_count;
   bit               req_taken;

   // mirrored scheduler state
   bit          t_used [NSLOT];
   logic [1:0]  t_state [NSLOT];
   logic [1:0]  t_base [NSLOT];
   logic [1:0]  t_eff [NSLOT];
   logic [31:0] t_last [NSLOT];
   logic [3:0]  lvl_q [NLVL][NSLOT];
   int          lvl_len [NLVL];
   bit          run_valid;
   logic [3:0]  run_slot;
   logic [31:0] tick_cnt;
   int          used_cnt;
   logic [31:0] cfg_threshold;
   logic [15:0] cfg_interval;
   logic [1:0]  cfg_new_prio;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void mirror_reset();
      for (int i = 0; i < NSLOT; i++) begin
         t_used[i] = 1'b0;
         t_state[i] = psa_pkg::TASK_READY;
         t_base[i] = 2'd0;
         t_eff[i] = 2'd0;
         t_last[i] = 32'd0;
      end
      t_used[0] = 1'b1;
      t_base[0] = 2'(NLVL - 1);
      t_eff[0] = 2'(NLVL - 1);
      for (int l = 0; l < NLVL; l++) lvl_len[l] = 0;
      run_valid = 1'b0;
      run_slot = 4'd0;
      tick_cnt = 32'd0;
      used_cnt = 1;
      cfg_threshold = 32'd20;
      cfg_interval = 16'd10;
      cfg_new_prio = 2'd2;
   endfunction

   function automatic bit lvl_push(int lv, logic [3:0] s);
      if (lvl_len[lv] >= NSLOT) return 1'b0;
      lvl_q[lv][lvl_len[lv]] = s;
      lvl_len[lv]++;
      return 1'b1;
   endfunction

   function automatic void lvl_drop_at(int lv, int idx);
      for (int k = idx; k + 1 < lvl_len[lv]; k++) lvl_q[lv][k] = lvl_q[lv][k+1];
      lvl_len[lv]--;
   endfunction

   function automatic void lvl_remove(int lv, logic [3:0] s);
      for (int k = 0; k < lvl_len[lv]; k++) begin
         if (lvl_q[lv][k] == s) begin
            lvl_drop_at(lv, k);
            return;
         end
      end
   endfunction

   // promote long-waiting tasks one level, lowest levels first
   function automatic void age_waiting();
      int k;
      logic [3:0] s;
      for (int lv = NLVL - 1; lv > 0; lv--) begin
         k = 0;
         while (k < lvl_len[lv]) begin
            s = lvl_q[lv][k];
            if (t_used[s] && (tick_cnt - t_last[s]) >= cfg_threshold &&
                lvl_len[lv-1] < NSLOT) begin
               lvl_drop_at(lv, k);
               t_eff[s] = 2'(lv - 1);
               t_last[s] = tick_cnt;
               void'(lvl_push(lv - 1, s));
            end else begin
               k++;
            end
         end
      end
   endfunction

   // head of the highest level that is still ready; stale entries are dropped
   function automatic bit pick_next(output logic [3:0] chosen);
      logic [3:0] s;
      chosen = 4'd0;
      for (int lv = 0; lv < NLVL; lv++) begin
         while (lvl_len[lv] > 0) begin
            s = lvl_q[lv][0];
            lvl_drop_at(lv, 0);
            if (t_used[s] && t_state[s] == psa_pkg::TASK_READY) begin
               chosen = s;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic sched_result_type schedule_event(logic [8:0] w);
      sched_result_type r;
      logic [2:0] mode;
      logic [3:0] slot;
      logic [3:0] c;
      logic [1:0] preq;
      logic [1:0] ob;
      logic [1:0] oe;
      bit         valid;
      bit         held;
      int         i;
      mode = w[2:0];
      slot = w[6:3];
      preq = w[8:7];
      valid = t_used[slot];
      r = '0;
      r.status = psa_pkg::STATUS_OK;
      r.slot = slot;
      case (mode)
         psa_pkg::MODE_TICK: begin
            held = 1'b0;
            if (run_valid) begin
               c = run_slot;
               tick_cnt++;
               t_eff[c] = t_base[c];
               if (t_state[c] == psa_pkg::TASK_RUNNING) t_state[c] = psa_pkg::TASK_READY;
               if (t_state[c] == psa_pkg::TASK_READY && c != 0 &&
                   !lvl_push(t_eff[c], c)) begin
                  // requeue found its level full: keep the current task
                  t_state[c] = psa_pkg::TASK_RUNNING;
                  r.status = psa_pkg::STATUS_FULL;
                  r.slot = c;
                  held = 1'b1;
               end
            end
            if (!held) begin
               if (cfg_interval != 0 && tick_cnt % cfg_interval == 0) age_waiting();
               if (!pick_next(c)) begin
                  c = 4'd0;
                  r.idle = 1'b1;
               end
               t_last[c] = tick_cnt;
               run_valid = 1'b1;
               run_slot = c;
               t_state[c] = psa_pkg::TASK_RUNNING;
               r.slot = c;
            end
         end
         psa_pkg::MODE_ADD: begin
            r.slot = 4'd0;
            if (used_cnt >= NSLOT) begin
               r.status = psa_pkg::STATUS_FULL;
            end else begin
               for (i = 0; i < NSLOT && t_used[i]; i++) ;
               if (i >= NSLOT || !lvl_push(cfg_new_prio, 4'(i))) begin
                  r.status = psa_pkg::STATUS_FULL;
               end else begin
                  t_used[i] = 1'b1;
                  t_state[i] = psa_pkg::TASK_READY;
                  t_base[i] = cfg_new_prio;
                  t_eff[i] = cfg_new_prio;
                  t_last[i] = tick_cnt;
                  used_cnt++;
                  r.slot = 4'(i);
               end
            end
         end
         psa_pkg::MODE_REMOVE, psa_pkg::MODE_BLOCK: begin
            if (!valid) begin
               r.status = psa_pkg::STATUS_BAD_SLOT;
            end else if (slot == 0) begin
               r.status = psa_pkg::STATUS_IDLE;
            end else begin
               if (t_state[slot] == psa_pkg::TASK_READY ||
                   t_state[slot] == psa_pkg::TASK_RUNNING)
                  lvl_remove(t_eff[slot], slot);
               if (mode == psa_pkg::MODE_REMOVE) begin
                  t_used[slot] = 1'b0;
                  used_cnt--;
               end else begin
                  t_state[slot] = psa_pkg::TASK_BLOCKED;
               end
               if (run_valid && run_slot == slot) begin
                  r.resched = 1'b1;
                  if (mode == psa_pkg::MODE_REMOVE) run_valid = 1'b0;
               end
            end
         end
         psa_pkg::MODE_UNBLOCK: begin
            if (!valid || t_state[slot] != psa_pkg::TASK_BLOCKED) begin
               r.status = psa_pkg::STATUS_BAD_SLOT;
            end else begin
               t_eff[slot] = t_base[slot];
               t_last[slot] = tick_cnt;
               if (lvl_push(t_eff[slot], slot)) t_state[slot] = psa_pkg::TASK_READY;
               else r.status = psa_pkg::STATUS_FULL;
            end
         end
         psa_pkg::MODE_SETPRIO: begin
            if (!valid) begin
               r.status = psa_pkg::STATUS_BAD_SLOT;
            end else if (slot == 0) begin
               r.status = psa_pkg::STATUS_IDLE;
            end else if (t_base[slot] != preq) begin
               ob = t_base[slot];
               oe = t_eff[slot];
               t_base[slot] = preq;
               t_eff[slot] = preq;
               if (t_state[slot] == psa_pkg::TASK_READY) begin
                  lvl_remove(oe, slot);
                  t_last[slot] = tick_cnt;
                  if (!lvl_push(preq, slot)) begin
                     t_base[slot] = ob;
                     t_eff[slot] = oe;
                     void'(lvl_push(oe, slot));
                     r.status = psa_pkg::STATUS_FULL;
                  end
               end
            end
         end
         psa_pkg::MODE_GETPRIO: begin
            if (!valid) r.status = psa_pkg::STATUS_BAD_SLOT;
            else r.prio = t_base[slot];
         end
         default: r.status = psa_pkg::STATUS_BAD_SLOT;
      endcase
      return r;
   endfunction

   // driver: words change on the falling edge
   always @(negedge clock) begin
      logic       nxt_valid;
      logic [8:0] nxt_word;
      nxt_valid = req_tvalid;
      nxt_word = req_tdata[8:0];
      if (!reset && (!req_tvalid || req_taken)) begin
         if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt_word = event_backlog.pop_front();
            nxt_valid = 1'b1;
         end else begin
            nxt_valid = 1'b0;
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata <= {7'd0, nxt_word};
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: check results, then predict for the word accepted at this edge
   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[2:0];
            got.slot = rsp_tdata[6:3];
            got.prio = rsp_tdata[8:7];
            got.resched = rsp_tdata[9];
            got.idle = rsp_tdata[10];
            if (sched_expected.size() == 0) begin
               err_count++;
               if (err_count <= 10) $display("unexpected result word %h", rsp_tdata);
            end else begin
               want = sched_expected.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.prio !== want.prio || got.resched !== want.resched ||
                   got.idle !== want.idle) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                              want.status, want.slot, want.prio, want.resched, want.idle,
                              got.status, got.slot, got.prio, got.resched, got.idle);
               end
            end
         end
         req_taken = !reset && req_tvalid && req_tready;
         if (req_taken) sched_expected.push_back(schedule_event(req_tdata[8:0]));
      end
   end

   function automatic logic [8:0] ev(logic [2:0] mode, logic [3:0] slot, logic [1:0] p);
      return {p, slot, mode};
   endfunction

   // random word, weighted toward ticks and valid task traffic
   function automatic logic [8:0] random_event();
      int unsigned roll;
      logic [2:0]  mode;
      roll = $urandom_range(99);
      if (roll < 34) mode = psa_pkg::MODE_TICK;
      else if (roll < 50) mode = psa_pkg::MODE_ADD;
      else if (roll < 58) mode = psa_pkg::MODE_REMOVE;
      else if (roll < 68) mode = psa_pkg::MODE_BLOCK;
      else if (roll < 80) mode = psa_pkg::MODE_UNBLOCK;
      else if (roll < 90) mode = psa_pkg::MODE_SETPRIO;
      else if (roll < 97) mode = psa_pkg::MODE_GETPRIO;
      else mode = 3'd7;
      return ev(mode, 4'($urandom_range(15)), 2'($urandom_range(3)));
   endfunction

   task automatic wait_drained();
      while (event_backlog.size() != 0 || req_tvalid || sched_expected.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // register write while the block is idle; mirror follows at once
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         psa_pkg::CSR_AGING_THRESHOLD: cfg_threshold = val;
         psa_pkg::CSR_AGING_INTERVAL: cfg_interval = val[15:0];
         psa_pkg::CSR_NEW_TASK_PRIO: cfg_new_prio = val[1:0];
         default: ;
      endcase
   endtask

   logic [31:0] thr_set [6] = '{32'd20, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'd5, 32'd1};
   logic [31:0] ivl_set [6] = '{32'd10, 32'd1, 32'd65535, 32'd2, 32'd1, 32'd3};
   logic [31:0] pri_set [6] = '{32'd2, 32'd0, 32'd3, 32'd1, 32'd2, 32'd3};

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      err_count = 0;
      cycle_count = 0;
      req_taken = 1'b0;
      send_idle_pct = 18;
      recv_idle_pct = 45;
      mirror_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle slot protection, bad slots, unknown mode, state errors
      event_backlog.push_back(ev(psa_pkg::MODE_TICK, 4'd0, 2'd0));
      repeat (4) event_backlog.push_back(ev(psa_pkg::MODE_ADD, 4'd0, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_GETPRIO, 4'd1, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_SETPRIO, 4'd1, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_SETPRIO, 4'd2, 2'd3));
      event_backlog.push_back(ev(psa_pkg::MODE_TICK, 4'd0, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_BLOCK, 4'd1, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_UNBLOCK, 4'd1, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_UNBLOCK, 4'd1, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_REMOVE, 4'd0, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_BLOCK, 4'd0, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_SETPRIO, 4'd0, 2'd1));
      event_backlog.push_back(ev(psa_pkg::MODE_GETPRIO, 4'd0, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_REMOVE, 4'd15, 2'd3));
      event_backlog.push_back(ev(3'd7, 4'd15, 2'd3));
      event_backlog.push_back(ev(psa_pkg::MODE_TICK, 4'd0, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_TICK, 4'd0, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_REMOVE, 4'd2, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_UNBLOCK, 4'd9, 2'd0));
      event_backlog.push_back(ev(psa_pkg::MODE_GETPRIO, 4'd15, 2'd3));
      wait_drained();

      // random phases, each under its own register setting and idle profile
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(psa_pkg::CSR_AGING_THRESHOLD, thr_set[ph]);
         write_csr(psa_pkg::CSR_AGING_INTERVAL, ivl_set[ph]);
         write_csr(psa_pkg::CSR_NEW_TASK_PRIO, pri_set[ph]);
         if (ph < 2) begin
            send_idle_pct = 18;
            recv_idle_pct = 45;
         end else if (ph < 4) begin
            send_idle_pct = 45;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 200; n++) event_backlog.push_back(random_event());
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (err_count == 0 && sched_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### priority_scheduler_with_aging_top.f
hdl/psa_pkg.sv
hdl/psa_cell.sv
hdl/psa_queue.sv
hdl/priority_scheduler_with_aging_top.sv
hdl/psa_checker.sv
sim/tb.sv
